### rtl/core/teq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package teq_pkg;

	// Detector state codes
	localparam logic [1:0] ST_IDLE      = 2'd0;
	localparam logic [1:0] ST_DETECTED  = 2'd1;
	localparam logic [1:0] ST_CONFIRMED = 2'd2;
	localparam logic [1:0] ST_INHIBITED = 2'd3;

	// Sensor count that confirms a detection at once
	localparam logic [1:0] QUICK_COUNT = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_INHIBIT_MS       = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_ACTIVE_COUNT = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STABLE_MS        = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_MS       = 8'd3;

	// Register reset values
	localparam logic [15:0] INHIBIT_MS_RST       = 16'd500;
	localparam logic [1:0]  MIN_ACTIVE_COUNT_RST = 2'd2;
	localparam logic [15:0] STABLE_MS_RST        = 16'd50;
	localparam logic [15:0] TIMEOUT_MS_RST       = 16'd300;

	// Operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_DONE   = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] now_ms;
		logic        sensor_outer_left;
		logic        sensor_left;
		logic        sensor_center_left;
	} sample_t;

	typedef struct packed {
		logic       turn_pending;
		logic [1:0] detector_state;
		logic [1:0] active_count;
	} result_t;

	typedef struct packed {
		logic [15:0] inhibit_ms;
		logic [1:0]  min_active_count;
		logic [15:0] stable_ms;
		logic [15:0] timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  fsm;
		logic [31:0] detect_start;
		logic [31:0] inhibit_start;
		logic [31:0] last_turn;
		logic        ready;
		logic [1:0]  count;
	} det_state_t;

endpackage

`default_nettype wire

### rtl/core/teq_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Next-state and result logic for one transaction.
module teq_step (
	input  teq_pkg::sample_t    item,
	input  teq_pkg::det_state_t cur,
	input  teq_pkg::cfg_t       cfg,
	output teq_pkg::det_state_t nxt,
	output teq_pkg::result_t    res
);

	logic [31:0] now;
	logic [31:0] since_turn;
	logic        window;
	logic        enter_inh;
	logic        leave_inh;
	logic [31:0] inh_start_a;
	logic [31:0] inh_elapsed;
	logic [31:0] det_elapsed;
	logic [31:0] stuck_limit;
	logic [1:0]  cnt;
	logic        trigger;

	assign now         = item.now_ms;
	assign since_turn  = now - cur.last_turn;
	assign window      = since_turn < {16'd0, cfg.inhibit_ms};
	assign enter_inh   = window && (cur.fsm != teq_pkg::ST_INHIBITED);
	assign leave_inh   = !window && (cur.fsm == teq_pkg::ST_INHIBITED);
	assign inh_start_a = enter_inh ? now : cur.inhibit_start;
	assign inh_elapsed = now - inh_start_a;
	assign det_elapsed = now - cur.detect_start;
	assign stuck_limit = {15'd0, cfg.timeout_ms, 1'b0};
	assign cnt         = {1'b0, item.sensor_outer_left} + {1'b0, item.sensor_left}
		+ {1'b0, item.sensor_center_left};
	assign trigger     = (cnt >= cfg.min_active_count) && !window;

	always_comb begin
		logic [1:0] fsm_a;
		nxt   = cur;
		fsm_a = cur.fsm;
		if (item.opcode == teq_pkg::OP_DONE) begin
			nxt.fsm           = teq_pkg::ST_INHIBITED;
			nxt.ready         = 1'b0;
			nxt.last_turn     = now;
			nxt.inhibit_start = now;
		end else begin
			if (enter_inh) begin
				fsm_a = teq_pkg::ST_INHIBITED;
			end else if (leave_inh) begin
				fsm_a = teq_pkg::ST_IDLE;
			end
			nxt.fsm           = fsm_a;
			nxt.inhibit_start = inh_start_a;
			nxt.count         = cnt;
			unique case (fsm_a)
				teq_pkg::ST_IDLE: begin
					if (trigger) begin
						nxt.fsm          = teq_pkg::ST_DETECTED;
						nxt.detect_start = now;
					end
				end
				teq_pkg::ST_DETECTED: begin
					if (cnt >= teq_pkg::QUICK_COUNT
						|| det_elapsed >= {16'd0, cfg.stable_ms}) begin
						nxt.fsm   = teq_pkg::ST_CONFIRMED;
						nxt.ready = 1'b1;
					end else if (det_elapsed >= {16'd0, cfg.timeout_ms}) begin
						nxt.fsm   = teq_pkg::ST_IDLE;
						nxt.ready = 1'b0;
					end
				end
				teq_pkg::ST_CONFIRMED: begin
					if (det_elapsed >= stuck_limit) begin
						nxt.fsm          = teq_pkg::ST_IDLE;
						nxt.ready        = 1'b0;
						nxt.detect_start = 32'd0;
					end
				end
				teq_pkg::ST_INHIBITED: begin
					if (inh_elapsed >= {16'd0, cfg.inhibit_ms}) begin
						nxt.fsm = teq_pkg::ST_IDLE;
					end
				end
			endcase
		end
	end

	assign res.turn_pending   = nxt.ready;
	assign res.detector_state = nxt.fsm;
	assign res.active_count   = nxt.count;

endmodule

`default_nettype wire

### rtl/core/turn_event_qualifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_ready  teq_pkg::sample_t
// result    out        result_valid / result_ready  teq_pkg::result_t
// cfg       in         cfg_valid / cfg_ready        cfg_index (8b), cfg_data (16b)
//
// Each transaction passes through the input register, then the step logic
// into the result register. A new transaction can be accepted every cycle
// while the result is not stalled; the state registers update when the
// input register hands its item on, so the next item sees them.
// Reset returns the registers to their defaults and the detector to idle.
// A stalled result holds; an empty input register still takes one more item.
module turn_event_qualifier_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   sample_valid,
	output logic                                  sample_ready,
	input  teq_pkg::sample_t                      sample,
	output logic                                  result_valid,
	input  wire                                   result_ready,
	output teq_pkg::result_t                      result,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [teq_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  wire [teq_pkg::CFG_DATA_W-1:0]         cfg_data
);

	teq_pkg::cfg_t       cfg_q;
	teq_pkg::det_state_t state_q;
	teq_pkg::det_state_t state_nxt;
	teq_pkg::sample_t    item_s1;
	teq_pkg::result_t    res_nxt;
	logic                valid_s1;
	logic                advance;

	// Configuration writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inhibit_ms       <= teq_pkg::INHIBIT_MS_RST;
			cfg_q.min_active_count <= teq_pkg::MIN_ACTIVE_COUNT_RST;
			cfg_q.stable_ms        <= teq_pkg::STABLE_MS_RST;
			cfg_q.timeout_ms       <= teq_pkg::TIMEOUT_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				teq_pkg::REG_INHIBIT_MS:       cfg_q.inhibit_ms       <= cfg_data;
				teq_pkg::REG_MIN_ACTIVE_COUNT: cfg_q.min_active_count <= cfg_data[1:0];
				teq_pkg::REG_STABLE_MS:        cfg_q.stable_ms        <= cfg_data;
				teq_pkg::REG_TIMEOUT_MS:       cfg_q.timeout_ms       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the input register into the result register whenever the
	// result register is empty or being emptied this cycle.
	assign advance      = !result_valid || result_ready;
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	// Hold the payload while stalled; load a new transaction otherwise.
	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			item_s1 <= sample;
		end
	end

	teq_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Commit the detector state only when the item moves on to the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.fsm           <= teq_pkg::ST_IDLE;
			state_q.detect_start  <= 32'd0;
			state_q.inhibit_start <= 32'd0;
			state_q.last_turn     <= 32'd0;
			state_q.ready         <= 1'b0;
			state_q.count         <= 2'd0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result <= res_nxt;
		end
	end

`ifndef SYNTH
	// Ready only ever rises on the way into the confirmed state.
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q.ready) |-> state_q.fsm == teq_pkg::ST_CONFIRMED)
		else $error("turn ready rose outside the confirmed state");

	// A completed turn always lands in inhibit with ready cleared.
	a_done_inhibit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && item_s1.opcode == teq_pkg::OP_DONE)
		|=> (state_q.fsm == teq_pkg::ST_INHIBITED && !state_q.ready))
		else $error("done transaction did not enter inhibit");

	// A stalled input register keeps its item.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled transaction");

	// The detector state never moves without a transaction leaving the input register.
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(state_q))
		else $error("detector state changed with no transaction");
`endif

endmodule

`default_nettype wire
